// ===== rtl/core/dustflx_pkg.sv =====
// Package for the dust emission flux cell: widths, fixed-point constants,
// the log2 table and the channel payload types. No dependencies.
package dustflx_pkg;

	localparam int WIND_W     = 16;
	localparam int WET_W      = 16;
	localparam int ERO_W      = 16;
	localparam int PRIOR_W    = 48;
	localparam int EMIS_W     = 48;
	localparam int BASE_W     = 16;
	localparam int TUNE_W     = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int ACCUM_BITS_DEF = 48;
	localparam int NUM_STAGES     = 9;

	localparam int LOG_EXP_W   = 4;
	localparam int LOG_TAB_W   = 17;
	localparam int LOG_LO_W    = 16;
	localparam int LOG_DIFF_W  = 12;
	localparam int LOG_FRAC_W  = 10;
	localparam int LOG_N_W     = 21;
	localparam int SLOPE_W     = 28;
	localparam int FAC_PROD_W  = 49;
	localparam int FACTOR_W    = 17;
	localparam int THRESH_W    = 33;
	localparam int SQ_W        = 2 * WIND_W;
	localparam int DU_W        = 32;
	localparam int A_W         = TUNE_W + ERO_W;
	localparam int B_W         = SQ_W + DU_W;
	localparam int HALF_W      = 32;
	localparam int PROD_W      = A_W + B_W;
	localparam int FLUX_SHIFT  = 56;
	localparam int FLUX_W      = PROD_W - FLUX_SHIFT;

	localparam logic [WET_W-1:0]      WET_LIMIT         = 16'd13107;
	localparam logic [WET_W-1:0]      DRY_FLOOR         = 16'd65;
	localparam logic [FACTOR_W-1:0]   FACTOR_AT_FLOOR   = 17'd39321;
	localparam logic [FAC_PROD_W-1:0] ONE_POINT_TWO_Q48 = 49'd337769972052787;
	localparam logic [SLOPE_W-1:0]    LOG_SLOPE_Q32     = 28'd258582797;
	localparam logic [THRESH_W-1:0]   DRY_THRESHOLD_Q24 = 33'd1677721600;

	localparam logic [BASE_W-1:0] THRESHOLD_BASE_RST = 16'd622;
	localparam logic [TUNE_W-1:0] EMIS_COEF_RST      = 32'd263882;

	// round(2^16 * log2(1 + k/32)), k = 0..32
	localparam logic [LOG_TAB_W-1:0] LOG2_TAB [33] = '{
		17'd0,     17'd2909,  17'd5732,  17'd8473,  17'd11136, 17'd13727, 17'd16248,
		17'd18704, 17'd21098, 17'd23433, 17'd25711, 17'd27936, 17'd30109, 17'd32234,
		17'd34312, 17'd36346, 17'd38336, 17'd40286, 17'd42196, 17'd44068, 17'd45904,
		17'd47705, 17'd49472, 17'd51207, 17'd52911, 17'd54584, 17'd56229, 17'd57845,
		17'd59434, 17'd60997, 17'd62534, 17'd64047, 17'd65536
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD_BASE = 8'd0,
		CFG_EMIS_COEF      = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [WIND_W-1:0]  wind_10m;
		logic [WET_W-1:0]   soil_wetness;
		logic [ERO_W-1:0]   erodibility;
		logic [PRIOR_W-1:0] prior_emission;
	} cell_req_t;

	typedef struct packed {
		logic [EMIS_W-1:0] new_emission;
		logic              emitting;
		logic              saturated;
	} emis_resp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_req_t;

endpackage

// ===== rtl/core/dustflx_if.sv =====
// Valid/ready channel interfaces of the dust emission flux cell: cell
// requests, emission results and register writes. Uses dustflx_pkg.
interface dustflx_in_if import dustflx_pkg::*; ();
	logic      valid;
	logic      ready;
	cell_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dustflx_out_if import dustflx_pkg::*; ();
	logic       valid;
	logic       ready;
	emis_resp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dustflx_cfg_if import dustflx_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/dust_emission_flux_cell.sv =====
// Top level of the dust emission flux cell: nine-stage pipeline with the
// register file. Uses dustflx_pkg, dustflx_if, dustflx_wet_factor, dustflx_mul_wide.
//
// Usage:
//   grid   - request channel, one grid cell per request (wind, wetness,
//            erodibility, prior emission).
//   flux   - result channel, updated emission plus emitting/saturated flags.
//   cfg    - register writes, always ready; index 0 threshold_base,
//            index 1 emission coefficient, other indices ignored. Write only
//            while no request is in flight.
// A request passes through the wetness log, the threshold, the wind excess,
// u^2*(u-t), the wide flux multiplier and the saturating sum, in that order.
// Throughput is one request per cycle while flux.ready does not stall the pipeline.
// Each stage holds its request while the next stage is full and stalled, so
// bubbles are squeezed out and new requests keep entering until every stage
// is full; the result register holds while flux.ready is low.
// Reset empties the pipeline and loads the register defaults.
module dust_emission_flux_cell import dustflx_pkg::*; #(
	parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dustflx_in_if.sink           grid,
	dustflx_out_if.source        flux,
	dustflx_cfg_if.sink          cfg
);

	localparam int SUM_W = ((ACCUM_BITS > FLUX_W) ? ACCUM_BITS : FLUX_W) + 1;

	logic [BASE_W-1:0]     threshold_base_q;
	logic [TUNE_W-1:0]     emis_coef_q;

	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES:1]   vld_in;
	logic [NUM_STAGES:1]   en;

	logic [WIND_W-1:0]     u_s1, u_s2, u_s3, u_s4;
	logic [SQ_W-1:0]       u2_s1, u2_s2, u2_s3, u2_s4, u2_s5;
	logic [A_W-1:0]        a_s1, a_s2, a_s3, a_s4, a_s5, a_s6;
	logic [ACCUM_BITS-1:0] prior_s1, prior_s2, prior_s3, prior_s4;
	logic [ACCUM_BITS-1:0] prior_s5, prior_s6, prior_s7, prior_s8;

	logic                  wet_s3;
	logic [FACTOR_W-1:0]   factor_s3;
	logic [THRESH_W-1:0]   t_s4;
	logic [THRESH_W-1:0]   u24;
	logic                  emit_s5, emit_s6, emit_s7, emit_s8;
	logic [DU_W-1:0]       du_s5;
	logic [B_W-1:0]        b_s6;
	logic [FLUX_W-1:0]     flux_s8;

	logic [SUM_W-1:0]      sum;
	logic [ACCUM_BITS-1:0] maxv;
	logic                  over;
	logic [ACCUM_BITS-1:0] result;
	emis_resp_t            resp_s9;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_base_q <= THRESHOLD_BASE_RST;
			emis_coef_q      <= EMIS_COEF_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_THRESHOLD_BASE: threshold_base_q <= cfg.data[BASE_W-1:0];
				CFG_EMIS_COEF:      emis_coef_q      <= cfg.data[TUNE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when it is empty or the next one moves
	always_comb begin
		en[NUM_STAGES] = !vld_q[NUM_STAGES] || flux.ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vld_in     = {vld_q[NUM_STAGES-1:1], grid.valid};
	assign grid.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NUM_STAGES; i++) begin
				if (en[i]) vld_q[i] <= vld_in[i];
			end
		end
	end

	// stages 1-3: wetness factor
	dustflx_wet_factor u_wet (
		.clk          (clk),
		.en           (en[3:1]),
		.soil_wetness (grid.data.soil_wetness),
		.wet_s3       (wet_s3),
		.factor_s3    (factor_s3)
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			u_s1     <= grid.data.wind_10m;
			u2_s1    <= SQ_W'(grid.data.wind_10m) * SQ_W'(grid.data.wind_10m);
			a_s1     <= A_W'(emis_coef_q) * A_W'(grid.data.erodibility);
			prior_s1 <= ACCUM_BITS'(grid.data.prior_emission);
		end
		if (en[2]) begin
			u_s2     <= u_s1;
			u2_s2    <= u2_s1;
			a_s2     <= a_s1;
			prior_s2 <= prior_s1;
		end
		if (en[3]) begin
			u_s3     <= u_s2;
			u2_s3    <= u2_s2;
			a_s3     <= a_s2;
			prior_s3 <= prior_s2;
		end
	end

	// stage 4: threshold, Q8.24
	always_ff @(posedge clk) begin
		if (en[4]) begin
			t_s4     <= wet_s3 ? THRESH_W'(threshold_base_q) * THRESH_W'(factor_s3)
				: DRY_THRESHOLD_Q24;
			u_s4     <= u_s3;
			u2_s4    <= u2_s3;
			a_s4     <= a_s3;
			prior_s4 <= prior_s3;
		end
	end

	// stage 5: emission test and wind excess
	assign u24 = {1'b0, u_s4, 16'd0};

	always_ff @(posedge clk) begin
		if (en[5]) begin
			emit_s5  <= (u24 > t_s4);
			du_s5    <= DU_W'(u24 - t_s4);
			u2_s5    <= u2_s4;
			a_s5     <= a_s4;
			prior_s5 <= prior_s4;
		end
	end

	// stage 6: u^2 * (u - t)
	always_ff @(posedge clk) begin
		if (en[6]) begin
			b_s6     <= B_W'(u2_s5) * B_W'(du_s5);
			emit_s6  <= emit_s5;
			a_s6     <= a_s5;
			prior_s6 <= prior_s5;
		end
	end

	// stages 7-8: flux = a * b / 2^56
	dustflx_mul_wide u_mul (
		.clk     (clk),
		.en      (en[8:7]),
		.a       (a_s6),
		.b       (b_s6),
		.flux_s2 (flux_s8)
	);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			emit_s7  <= emit_s6;
			prior_s7 <= prior_s6;
		end
		if (en[8]) begin
			emit_s8  <= emit_s7;
			prior_s8 <= prior_s7;
		end
	end

	// stage 9: saturating accumulate into the result register
	always_comb begin
		maxv = {ACCUM_BITS{1'b1}};
		sum  = SUM_W'(prior_s8) + SUM_W'(flux_s8);
		over = (sum > SUM_W'(maxv));
		if (!emit_s8) result = prior_s8;
		else if (over) result = maxv;
		else result = sum[ACCUM_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			resp_s9.new_emission <= EMIS_W'(result);
			resp_s9.emitting     <= emit_s8;
			resp_s9.saturated    <= emit_s8 && over;
		end
	end

	assign flux.valid = vld_q[NUM_STAGES];
	assign flux.data  = resp_s9;

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!grid.ready |-> vld_q[1])
		else $error("request stalled with stage 1 empty");

	a_sat_needs_emit: assert property (@(posedge clk) disable iff (!arst_n)
		flux.valid && flux.data.saturated |-> flux.data.emitting)
		else $error("saturated result without emission");

	a_sat_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		flux.valid && flux.data.saturated
		|-> flux.data.new_emission == EMIS_W'({ACCUM_BITS{1'b1}}))
		else $error("saturated result not at accumulator maximum");
`endif

endmodule

// ===== rtl/core/dustflx_wet_factor.sv =====
// Three-stage wetness factor 1.2 + 0.2*log10(max(0.001, w)) in Q16:
// normalize and table lookup, interpolate, scale. Uses dustflx_pkg.
module dustflx_wet_factor import dustflx_pkg::*; (
	input  logic                clk,
	input  logic [2:0]          en,
	input  logic [WET_W-1:0]    soil_wetness,
	output logic                wet_s3,
	output logic [FACTOR_W-1:0] factor_s3
);

	logic [LOG_EXP_W-1:0]  msb;
	logic [WET_W-1:0]      norm;
	logic [4:0]            k;
	logic [LOG_TAB_W-1:0]  tab_lo;
	logic [LOG_TAB_W-1:0]  tab_hi;

	logic                  wet_s1;
	logic                  flr_s1;
	logic [LOG_EXP_W-1:0]  msb_s1;
	logic [LOG_LO_W-1:0]   lo_s1;
	logic [LOG_DIFF_W-1:0] diff_s1;
	logic [LOG_FRAC_W-1:0] frac_s1;

	logic [LOG_DIFF_W+LOG_FRAC_W-1:0] interp;
	logic [LOG_TAB_W-1:0]  lg;
	logic [LOG_N_W-1:0]    nlog;

	logic                  wet_s2;
	logic                  flr_s2;
	logic [LOG_N_W-1:0]    nlog_s2;

	logic [FAC_PROD_W-1:0] nprod;
	logic [FAC_PROD_W-1:0] fac_full;

	// stage 1: leading one, normalize, table pair
	always_comb begin
		msb = '0;
		for (int i = 1; i < WET_W; i++) begin
			if (soil_wetness[i]) msb = LOG_EXP_W'(i);
		end
		norm   = soil_wetness << (4'd15 - msb);
		k      = norm[14:10];
		tab_lo = LOG2_TAB[{1'b0, k}];
		tab_hi = LOG2_TAB[{1'b0, k} + 6'd1];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			wet_s1  <= (soil_wetness <= WET_LIMIT);
			flr_s1  <= (soil_wetness <= DRY_FLOOR);
			msb_s1  <= msb;
			lo_s1   <= LOG_LO_W'(tab_lo);
			diff_s1 <= LOG_DIFF_W'(tab_hi - tab_lo);
			frac_s1 <= norm[LOG_FRAC_W-1:0];
		end
	end

	// stage 2: interpolate, n = -log2(w) in Q16
	always_comb begin
		interp = diff_s1 * frac_s1;
		lg     = {1'b0, lo_s1} + LOG_TAB_W'(interp[LOG_DIFF_W+LOG_FRAC_W-1:LOG_FRAC_W]);
		nlog   = {5'd16 - {1'b0, msb_s1}, 16'd0} - {{(LOG_N_W-LOG_TAB_W){1'b0}}, lg};
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			wet_s2  <= wet_s1;
			flr_s2  <= flr_s1;
			nlog_s2 <= nlog;
		end
	end

	// stage 3: scale by 0.2*log10(2) and offset by 1.2
	always_comb begin
		nprod    = {{(FAC_PROD_W-LOG_N_W){1'b0}}, nlog_s2}
			* {{(FAC_PROD_W-SLOPE_W){1'b0}}, LOG_SLOPE_Q32};
		fac_full = ONE_POINT_TWO_Q48 - nprod;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			wet_s3    <= wet_s2;
			factor_s3 <= flr_s2 ? FACTOR_AT_FLOOR : fac_full[FAC_PROD_W-1:32];
		end
	end

endmodule

// ===== rtl/core/dustflx_mul_wide.sv =====
// Two-stage 48 x 64 multiplier giving product bits 111:56: four partial
// products, then one combining add. Uses dustflx_pkg.
module dustflx_mul_wide import dustflx_pkg::*; (
	input  logic              clk,
	input  logic [1:0]        en,
	input  logic [A_W-1:0]    a,
	input  logic [B_W-1:0]    b,
	output logic [FLUX_W-1:0] flux_s2
);

	logic [2*HALF_W-1:0]       pp_ll_s1;
	logic [2*HALF_W-1:0]       pp_lh_s1;
	logic [A_W-HALF_W+HALF_W-1:0] pp_hl_s1;
	logic [A_W-HALF_W+HALF_W-1:0] pp_hh_s1;
	logic [2*HALF_W:0]         mid;
	logic [PROD_W-1:0]         prod;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pp_ll_s1 <= a[HALF_W-1:0] * b[HALF_W-1:0];
			pp_lh_s1 <= a[HALF_W-1:0] * b[B_W-1:HALF_W];
			pp_hl_s1 <= a[A_W-1:HALF_W] * b[HALF_W-1:0];
			pp_hh_s1 <= a[A_W-1:HALF_W] * b[B_W-1:HALF_W];
		end
	end

	always_comb begin
		mid  = (2*HALF_W+1)'(pp_lh_s1) + (2*HALF_W+1)'(pp_hl_s1);
		prod = PROD_W'(pp_ll_s1) + (PROD_W'(mid) << HALF_W)
			+ (PROD_W'(pp_hh_s1) << (2*HALF_W));
	end

	always_ff @(posedge clk) begin
		if (en[1]) flux_s2 <= prod[PROD_W-1:FLUX_SHIFT];
	end

endmodule
